### rtl/maf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package maf_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 24;

    // Width and reset value of the window length register.
    localparam int            LEN_BITS  = 7;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd16;

    // Codes of the action field.
    localparam logic ACTION_PUSH  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

endpackage

`default_nettype wire

### rtl/maf_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface maf_in_if #(
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

interface maf_out_if #(
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

`default_nettype wire

### rtl/maf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module maf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/maf_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module maf_divider #(
    parameter int SUM_W = 30,
    parameter int DIV_W = 7,
    parameter int OUT_W = 24
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] dividend,
    input  wire logic        [DIV_W-1:0] divisor,
    output logic                         done,
    output logic signed [OUT_W-1:0]      quotient
);

    localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] dq_reg, dq_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] divisor_reg, divisor_next;
    logic             neg_reg, neg_next;

    logic [DIV_W:0]   rem_shift;
    logic             fits;
    logic [SUM_W-1:0] signed_q;

    // Restoring division of the magnitude, one quotient bit per cycle.
    // The dividend shifts out of dq_reg while quotient bits shift in.
    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[SUM_W-1]};
        fits      = (rem_shift >= {1'b0, divisor_reg});

        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;

        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(SUM_W - 1);
            neg_next     = dividend[SUM_W-1];
            dq_next      = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[SUM_W-2:0], fits};
            rem_next = fits ? DIV_W'(rem_shift - {1'b0, divisor_reg})
                            : rem_shift[DIV_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
    end

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign signed_q = neg_reg ? (~dq_reg + 1'b1) : dq_reg;
    assign quotient = signed_q[OUT_W-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

### rtl/moving_average_filter.sv
// Boxcar average of the last window_length samples, clamped to 1..MAX_WINDOW.
// Words arrive on the samples channel (action, sample) and leave on the
// results channel (average), both valid/ready; a word moves at a clock edge
// where valid and ready are both high. Every input word gives one result:
// a push replaces the oldest sample of the ring and returns the new average,
// a clear empties the ring and returns zero.
// The block works on one word at a time. The accepting edge also reads the
// oldest entry of the ring; the word then updates the ring and the running
// sum, passes through the bit-serial divider, hands over the quotient and
// loads the output register. A new word is taken only once the last one has
// left the divider for the output register.
// A finished result waits in the output register while the receiver stalls;
// the next word is still accepted, and its result waits in the divider until
// the output register is free.
// Reset clears the ring, the sum and the position and sets window_length to
// 16. Writing window_length clears them too; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_filter #(
    parameter int MAX_WINDOW  = maf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [maf_pkg::LEN_BITS-1:0]  cfg_wr_data,
    maf_in_if.sink                             samples,
    maf_out_if.source                          results
);

    import maf_pkg::*;

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int EFF_W = PTR_W + 1;
    localparam int SUM_W = SAMPLE_BITS + PTR_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_HOLD   = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [LEN_BITS-1:0]           len_reg, len_next;
    logic [PTR_W-1:0]              pos_reg, pos_next;
    logic                          full_reg, full_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic                          act_reg, act_next;
    logic signed [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_avg_reg, out_avg_next;

    logic [EFF_W-1:0]              eff_len;
    logic [EFF_W-1:0]              pos_plus;
    logic                          wrap;
    logic                          accept;
    logic                          ram_we;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] oldest;
    logic                          div_start;
    logic                          div_done;
    logic signed [SAMPLE_BITS-1:0] div_q;

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = EFF_W'(1);
        end
        else if (int'(len_reg) > MAX_WINDOW)
        begin
            eff_len = EFF_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = EFF_W'(len_reg);
        end
    end

    assign accept   = samples.valid && samples.ready;
    assign pos_plus = {1'b0, pos_reg} + 1'b1;
    assign wrap     = (pos_plus >= eff_len);

    // Entries are written in order from position zero after every clear, so
    // the entry under the write position holds data only once the ring has
    // wrapped; until then it counts as zero.
    assign oldest = full_reg ? ram_rdata : '0;

    assign ram_we    = (state_reg == ST_UPDATE) && (act_reg == ACTION_PUSH);
    assign div_start = (state_reg == ST_UPDATE);

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (smp_reg),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    maf_divider #(
        .SUM_W (SUM_W),
        .DIV_W (EFF_W),
        .OUT_W (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (eff_len),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        act_next       = act_reg;
        smp_next       = smp_reg;
        out_valid_next = out_valid_reg;
        out_avg_next   = out_avg_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = samples.action;
                    smp_next   = samples.sample;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (act_reg == ACTION_CLEAR)
                begin
                    sum_next  = '0;
                    pos_next  = '0;
                    full_next = 1'b0;
                end
                else
                begin
                    sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(smp_reg);
                    pos_next = wrap ? '0 : pos_plus[PTR_W-1:0];
                    if (wrap)
                    begin
                        full_next = 1'b1;
                    end
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = div_q;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            len_next  = cfg_wr_data;
            sum_next  = '0;
            pos_next  = '0;
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            pos_reg       <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            full_reg      <= full_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        smp_reg     <= smp_next;
        out_avg_reg <= out_avg_next;
    end

    assign samples.ready   = (state_reg == ST_IDLE);
    assign results.valid   = out_valid_reg;
    assign results.average = out_avg_reg;

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < eff_len)
        else $error("write position outside the window");

    a_full_at_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full_reg) |-> pos_reg == '0)
        else $error("ring marked full away from position zero");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && act_reg == ACTION_CLEAR)
        |=> (sum_reg == '0 && pos_reg == '0 && !full_reg))
        else $error("clear word left state behind");

    a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_HOLD)
        else $error("result raised outside the hold phase");

endmodule

`default_nettype wire
